// File: design/cetr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetr_pkg
// Shared types and constants of the cubic energy term reduction block.
// ----------------------------------------------------------------------------

package cetr_pkg;

    // Width of every result energy, fixed by the result format.
    localparam int W_BITS = 28;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;

    // Position of a result term within the sequence of one item.
    typedef logic [2:0] t_term_idx;

    localparam t_term_idx TERM_PQ   = 3'd0;
    localparam t_term_idx TERM_PR   = 3'd1;
    localparam t_term_idx TERM_QR   = 3'd2;
    localparam t_term_idx TERM_AUX  = 3'd3;
    localparam t_term_idx TERM_PAUX = 3'd4;
    localparam t_term_idx TERM_QAUX = 3'd5;
    localparam t_term_idx TERM_RAUX = 3'd6;

    // Kind of a result term, carried on the output tuser.
    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_UNARY = 1'b1;

    // Placement of the two computed differences in the w00..w11 slots.
    // PL_A_B puts the first difference in slot A and the second in slot B.
    typedef enum logic [2:0] {
        PL_01_11,
        PL_10_11,
        PL_00_10,
        PL_00_01,
        PL_01,
        PL_10
    } t_place;

    // Classification of one item made by the front.
    typedef struct packed {
        logic pi_zero;
        logic pi_neg;
    } t_item_ctl;

endpackage

// File: design/cetr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetr_front
// Accepts cubic terms, forms pi, allocates the auxiliary node and writes one
// classified entry per item into the queue.
// ----------------------------------------------------------------------------

module cetr_front #(
    parameter int NODE_BITS   = 20,
    parameter int ENERGY_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write
    input  logic                                i_cfg_valid,
    input  logic [NODE_BITS-1:0]                i_cfg_data,
    // Input beat
    input  logic                                i_s_valid,
    output logic                                o_s_ready,
    input  logic signed [ENERGY_BITS-1:0]       i_e000,
    input  logic signed [ENERGY_BITS-1:0]       i_e001,
    input  logic signed [ENERGY_BITS-1:0]       i_e010,
    input  logic signed [ENERGY_BITS-1:0]       i_e011,
    input  logic signed [ENERGY_BITS-1:0]       i_e100,
    input  logic signed [ENERGY_BITS-1:0]       i_e101,
    input  logic signed [ENERGY_BITS-1:0]       i_e110,
    input  logic signed [ENERGY_BITS-1:0]       i_e111,
    // Queue write side
    input  logic                                i_q_full,
    output logic                                o_push,
    output logic signed [ENERGY_BITS+2:0]       o_pi,
    output logic [NODE_BITS-1:0]                o_aux_node,
    output logic [NODE_BITS-1:0]                o_node_total,
    output cetr_pkg::t_item_ctl                 o_ctl
);

    localparam int PW = ENERGY_BITS + 3;
    localparam logic [NODE_BITS-1:0] NODE_LIMIT = '1;

    logic [NODE_BITS-1:0]  r_base;
    logic [NODE_BITS-1:0]  r_aux_added;
    logic [NODE_BITS-1:0]  n_aux_added;
    logic signed [PW-1:0]  even_sum;
    logic signed [PW-1:0]  odd_sum;
    logic signed [PW-1:0]  pi;
    logic [NODE_BITS:0]    node_sum;
    logic                  room;
    logic                  alloc;
    logic                  accept;

    // Parity sums of the energy table.
    always_comb begin
        even_sum = PW'(i_e000) + PW'(i_e011) + PW'(i_e101) + PW'(i_e110);
        odd_sum  = PW'(i_e001) + PW'(i_e010) + PW'(i_e100) + PW'(i_e111);
        pi       = even_sum - odd_sum;
    end

    // Auxiliary node allocation with saturation at the node limit.
    always_comb begin
        node_sum = {1'b0, r_base} + {1'b0, r_aux_added};
        room     = node_sum < {1'b0, NODE_LIMIT};
        alloc    = (pi != '0) && room;
        accept   = i_s_valid && !i_q_full;

        o_s_ready  = !i_q_full;
        o_push     = accept;
        o_pi       = pi;
        o_aux_node = room ? node_sum[NODE_BITS-1:0] : NODE_LIMIT;
        if (alloc) begin
            o_node_total = node_sum[NODE_BITS-1:0] + NODE_BITS'(1);
        end else begin
            o_node_total = room ? node_sum[NODE_BITS-1:0] : NODE_LIMIT;
        end
        o_ctl.pi_zero = (pi == '0);
        o_ctl.pi_neg  = pi[PW-1];

        n_aux_added = (accept && alloc) ? r_aux_added + NODE_BITS'(1) : r_aux_added;
    end

    // Base count register and auxiliary counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_aux_added <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            r_aux_added <= n_aux_added;
        end
    end

    // The counter only grows; it stops below the limit, so it never wraps.
    a_aux_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1 |=> (r_aux_added >= $past(r_aux_added)))
        else $error("auxiliary node counter went backward");

endmodule

// File: design/cetr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetr_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------

module cetr_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_head
);

    localparam int PB = cetr_pkg::Q_PTR_BITS;

    logic [DATA_W-1:0] r_mem [cetr_pkg::Q_DEPTH];
    logic [PB:0]       r_wptr;
    logic [PB:0]       r_rptr;

    // Full when the pointers differ only in the wrap bit.
    always_comb begin
        o_empty = (r_wptr == r_rptr);
        o_full  = (r_wptr[PB] != r_rptr[PB]) && (r_wptr[PB-1:0] == r_rptr[PB-1:0]);
        o_head  = r_mem[r_rptr[PB-1:0]];
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr[PB-1:0]] <= i_push_data;
        end
    end

    // Pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + (PB+1)'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + (PB+1)'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

endmodule

// File: design/cetr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetr_back
// Term sequencer: walks the head queue entry through its three or seven
// result terms and holds each one in the output register.
// ----------------------------------------------------------------------------

module cetr_back #(
    parameter int NODE_BITS   = 20,
    parameter int ENERGY_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Queue read side
    input  logic                                i_empty,
    output logic                                o_pop,
    input  logic [NODE_BITS-1:0]                i_node_p,
    input  logic [NODE_BITS-1:0]                i_node_q,
    input  logic [NODE_BITS-1:0]                i_node_r,
    input  logic signed [ENERGY_BITS-1:0]       i_e000,
    input  logic signed [ENERGY_BITS-1:0]       i_e001,
    input  logic signed [ENERGY_BITS-1:0]       i_e010,
    input  logic signed [ENERGY_BITS-1:0]       i_e011,
    input  logic signed [ENERGY_BITS-1:0]       i_e100,
    input  logic signed [ENERGY_BITS-1:0]       i_e101,
    input  logic signed [ENERGY_BITS-1:0]       i_e110,
    input  logic signed [ENERGY_BITS-1:0]       i_e111,
    input  logic signed [ENERGY_BITS+2:0]       i_pi,
    input  logic [NODE_BITS-1:0]                i_aux_node,
    input  logic [NODE_BITS-1:0]                i_node_total,
    input  cetr_pkg::t_item_ctl                 i_ctl,
    // Result beat
    input  logic                                i_m_ready,
    output logic                                o_m_valid,
    output logic                                o_term_kind,
    output logic [NODE_BITS-1:0]                o_first_node,
    output logic [NODE_BITS-1:0]                o_second_node,
    output logic [cetr_pkg::W_BITS-1:0]         o_w00,
    output logic [cetr_pkg::W_BITS-1:0]         o_w01,
    output logic [cetr_pkg::W_BITS-1:0]         o_w10,
    output logic [cetr_pkg::W_BITS-1:0]         o_w11,
    output logic                                o_nonsubmodular,
    output logic [NODE_BITS-1:0]                o_node_total,
    output logic                                o_last_term
);

    localparam int WB = cetr_pkg::W_BITS;
    localparam int EW = ENERGY_BITS + 5;
    localparam int XW = ((EW > WB) ? EW : WB) + 1;
    localparam logic signed [XW-1:0] W_MAX_X = (XW'(1) <<< (WB - 1)) - XW'(1);
    localparam logic signed [XW-1:0] W_MIN_X = -W_MAX_X - XW'(1);

    // Clamp a wide energy to the signed result range.
    function automatic logic [WB-1:0] sat_w(input logic signed [EW-1:0] v);
        logic signed [XW-1:0] vx;
        vx = XW'(v);
        if (vx > W_MAX_X) begin
            vx = W_MAX_X;
        end else if (vx < W_MIN_X) begin
            vx = W_MIN_X;
        end
        return vx[WB-1:0];
    endfunction

    cetr_pkg::t_term_idx r_idx;
    cetr_pkg::t_term_idx n_idx;
    cetr_pkg::t_place    place;

    logic signed [EW-1:0] ea, eb, ec, ed, ee, ef, eg, eh, ep;
    logic signed [EW-1:0] x1, y1, x2, y2, d1, d2;
    logic signed [EW-1:0] w00, w01, w10, w11;
    logic                 add1;
    logic                 pair;
    logic                 ns;
    logic                 last;
    logic                 load;
    logic [NODE_BITS-1:0] n1;
    logic [NODE_BITS-1:0] n2;

    logic                 r_valid;
    logic                 r_kind;
    logic [NODE_BITS-1:0] r_first;
    logic [NODE_BITS-1:0] r_second;
    logic [WB-1:0]        r_w00;
    logic [WB-1:0]        r_w01;
    logic [WB-1:0]        r_w10;
    logic [WB-1:0]        r_w11;
    logic                 r_ns;
    logic [NODE_BITS-1:0] r_total;
    logic                 r_last;

    // Operand selection for the current term.
    always_comb begin
        ea = EW'(i_e000);
        eb = EW'(i_e001);
        ec = EW'(i_e010);
        ed = EW'(i_e011);
        ee = EW'(i_e100);
        ef = EW'(i_e101);
        eg = EW'(i_e110);
        eh = EW'(i_e111);
        ep = EW'(i_pi);

        x1    = '0;
        y1    = '0;
        x2    = '0;
        y2    = '0;
        add1  = 1'b0;
        pair  = 1'b0;
        place = cetr_pkg::PL_01_11;
        n1    = '0;
        n2    = '0;

        unique case (r_idx)
            cetr_pkg::TERM_PQ: begin
                pair = 1'b1;
                n1   = i_node_p;
                n2   = i_node_q;
                if (i_ctl.pi_neg) begin
                    x1 = eb; y1 = ed; x2 = ef; y2 = eh;
                    place = cetr_pkg::PL_00_10;
                end else begin
                    x1 = ec; y1 = ea; x2 = eg; y2 = ee;
                    place = cetr_pkg::PL_01_11;
                end
            end
            cetr_pkg::TERM_PR: begin
                pair = 1'b1;
                n1   = i_node_p;
                n2   = i_node_r;
                if (i_ctl.pi_neg) begin
                    x1 = ec; y1 = eg; x2 = ed; y2 = eh;
                    place = cetr_pkg::PL_00_01;
                end else begin
                    x1 = ee; y1 = ea; x2 = ef; y2 = eb;
                    place = cetr_pkg::PL_10_11;
                end
            end
            cetr_pkg::TERM_QR: begin
                pair = 1'b1;
                n1   = i_node_q;
                n2   = i_node_r;
                if (i_ctl.pi_neg) begin
                    x1 = ee; y1 = ef; x2 = eg; y2 = eh;
                    place = cetr_pkg::PL_00_10;
                end else begin
                    x1 = eb; y1 = ea; x2 = ed; y2 = ec;
                    place = cetr_pkg::PL_01_11;
                end
            end
            cetr_pkg::TERM_AUX: begin
                n1    = i_aux_node;
                place = cetr_pkg::PL_00_01;
                if (i_ctl.pi_neg) begin
                    x1 = eh; y1 = ep; add1 = 1'b1; x2 = eh;
                end else begin
                    x1 = ea; x2 = ea; y2 = ep;
                end
            end
            cetr_pkg::TERM_PAUX, cetr_pkg::TERM_QAUX, cetr_pkg::TERM_RAUX: begin
                n2 = i_aux_node;
                if (r_idx == cetr_pkg::TERM_PAUX) begin
                    n1 = i_node_p;
                end else if (r_idx == cetr_pkg::TERM_QAUX) begin
                    n1 = i_node_q;
                end else begin
                    n1 = i_node_r;
                end
                if (i_ctl.pi_neg) begin
                    y1    = ep;
                    place = cetr_pkg::PL_10;
                end else begin
                    x1    = ep;
                    place = cetr_pkg::PL_01;
                end
            end
            default: begin
                n1 = '0;
            end
        endcase
    end

    // Differences, slot placement and the submodularity test.
    always_comb begin
        d1 = add1 ? x1 + y1 : x1 - y1;
        d2 = x2 - y2;
        ns = pair && (i_ctl.pi_neg ? (d2 < d1) : (d1 < d2));

        w00 = '0;
        w01 = '0;
        w10 = '0;
        w11 = '0;
        unique case (place)
            cetr_pkg::PL_01_11: begin w01 = d1; w11 = d2; end
            cetr_pkg::PL_10_11: begin w10 = d1; w11 = d2; end
            cetr_pkg::PL_00_10: begin w00 = d1; w10 = d2; end
            cetr_pkg::PL_00_01: begin w00 = d1; w01 = d2; end
            cetr_pkg::PL_01:    begin w01 = d1; end
            cetr_pkg::PL_10:    begin w10 = d1; end
            default:            begin w00 = '0; end
        endcase
    end

    // Sequencer advance: one term per cycle whenever the queue holds an entry and the output slot frees up.
    always_comb begin
        last  = (r_idx == (i_ctl.pi_zero ? cetr_pkg::TERM_QR : cetr_pkg::TERM_RAUX));
        load  = !i_empty && (!r_valid || i_m_ready);
        o_pop = load && last;
        if (load) begin
            n_idx = last ? cetr_pkg::TERM_PQ : r_idx + 3'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= cetr_pkg::TERM_PQ;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= (r_idx == cetr_pkg::TERM_AUX) ? cetr_pkg::KIND_UNARY
                                                      : cetr_pkg::KIND_PAIR;
            r_first  <= n1;
            r_second <= n2;
            r_w00    <= sat_w(w00);
            r_w01    <= sat_w(w01);
            r_w10    <= sat_w(w10);
            r_w11    <= sat_w(w11);
            r_ns     <= ns;
            r_total  <= i_node_total;
            r_last   <= last;
        end
    end

    always_comb begin
        o_m_valid       = r_valid;
        o_term_kind     = r_kind;
        o_first_node    = r_first;
        o_second_node   = r_second;
        o_w00           = r_w00;
        o_w01           = r_w01;
        o_w10           = r_w10;
        o_w11           = r_w11;
        o_nonsubmodular = r_ns;
        o_node_total    = r_total;
        o_last_term     = r_last;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= cetr_pkg::TERM_RAUX)
        else $error("term index out of range");

    a_idx_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != cetr_pkg::TERM_PQ) |-> !i_empty)
        else $error("sequencer mid-item without a queue entry");

    a_unary_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == cetr_pkg::KIND_UNARY) |-> (!r_ns && r_second == '0))
        else $error("unary term carries a pairwise attribute");

endmodule

// File: design/cubic_energy_term_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_energy_term_reduction
// Reduces a third-order binary energy term to pairwise terms, adding one
// auxiliary node with a unary term when the cubic coefficient is nonzero.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Moves
//  --------  ---------  ------------------------  ------------------------------
//  cfg       in         i_cfg_valid / o_cfg_ready base_node_count
//  s         in         i_s_tvalid / o_s_tready   one cubic term per beat
//  m         out        o_m_tvalid / i_m_tready   one result term per beat
//
//  Each item yields 3 result beats when pi is zero and 7 otherwise; the result
//  channel moves one beat per cycle while the queue holds entries and i_m_tready
//  is high. The first result of an item is loaded into the output register once
//  the item reaches the head of the 4-entry queue and that register is free;
//  input beats keep flowing while results wait. Reset clears the base count, the
//  auxiliary counter, the queue and the output valid flag. A stalled result
//  channel backs up into the queue, which drops o_s_tready only when full.
//

module cubic_energy_term_reduction #(
    parameter int NODE_BITS   = 20,
    parameter int ENERGY_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [NODE_BITS-1:0] i_cfg_data,
    // Input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // node_p, node_q, node_r, e000, e001, e010, e011, e100, e101, e110, e111
    input  logic [((3*NODE_BITS + 8*ENERGY_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // Result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // first_node, second_node, w00, w01, w10, w11, nonsubmodular, node_total
    output logic [((3*NODE_BITS + 4*cetr_pkg::W_BITS + 1 + 7) / 8) * 8 - 1:0] o_m_tdata,
    // term_kind
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    localparam int NB    = NODE_BITS;
    localparam int EB    = ENERGY_BITS;
    localparam int PW    = EB + 3;
    localparam int WB    = cetr_pkg::W_BITS;
    localparam int OFF_E = 3 * NB;
    localparam int OUT_W = ((3*NB + 4*WB + 1 + 7) / 8) * 8;
    localparam int ENT_W = 3*NB + 8*EB + PW + 2*NB + $bits(cetr_pkg::t_item_ctl);

    logic [NB-1:0]        s_p, s_q, s_r;
    logic signed [EB-1:0] s_e [8];

    logic                 f_push;
    logic signed [PW-1:0] f_pi;
    logic [NB-1:0]        f_aux;
    logic [NB-1:0]        f_total;
    cetr_pkg::t_item_ctl  f_ctl;

    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic [ENT_W-1:0]     q_in;
    logic [ENT_W-1:0]     q_head;

    logic [NB-1:0]        h_p, h_q, h_r;
    logic signed [EB-1:0] h_e000, h_e001, h_e010, h_e011;
    logic signed [EB-1:0] h_e100, h_e101, h_e110, h_e111;
    logic signed [PW-1:0] h_pi;
    logic [NB-1:0]        h_aux;
    logic [NB-1:0]        h_total;
    cetr_pkg::t_item_ctl  h_ctl;

    logic [NB-1:0]        b_first, b_second, b_total;
    logic [WB-1:0]        b_w00, b_w01, b_w10, b_w11;
    logic                 b_ns;

    // Unpack the input beat.
    always_comb begin
        s_p = i_s_tdata[0 +: NB];
        s_q = i_s_tdata[NB +: NB];
        s_r = i_s_tdata[2*NB +: NB];
        for (int k = 0; k < 8; k++) begin
            s_e[k] = i_s_tdata[OFF_E + k*EB +: EB];
        end
    end

    assign o_cfg_ready = 1'b1;

    cetr_front #(
        .NODE_BITS   (NB),
        .ENERGY_BITS (EB)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_s_valid    (i_s_tvalid),
        .o_s_ready    (o_s_tready),
        .i_e000       (s_e[0]),
        .i_e001       (s_e[1]),
        .i_e010       (s_e[2]),
        .i_e011       (s_e[3]),
        .i_e100       (s_e[4]),
        .i_e101       (s_e[5]),
        .i_e110       (s_e[6]),
        .i_e111       (s_e[7]),
        .i_q_full     (q_full),
        .o_push       (f_push),
        .o_pi         (f_pi),
        .o_aux_node   (f_aux),
        .o_node_total (f_total),
        .o_ctl        (f_ctl)
    );

    // Queue entry: raw term plus what the front worked out for it.
    assign q_in = {f_ctl, f_total, f_aux, f_pi,
                   s_e[7], s_e[6], s_e[5], s_e[4], s_e[3], s_e[2], s_e[1], s_e[0],
                   s_r, s_q, s_p};

    cetr_queue #(
        .DATA_W (ENT_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    assign {h_ctl, h_total, h_aux, h_pi,
            h_e111, h_e110, h_e101, h_e100, h_e011, h_e010, h_e001, h_e000,
            h_r, h_q, h_p} = q_head;

    cetr_back #(
        .NODE_BITS   (NB),
        .ENERGY_BITS (EB)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .i_node_p        (h_p),
        .i_node_q        (h_q),
        .i_node_r        (h_r),
        .i_e000          (h_e000),
        .i_e001          (h_e001),
        .i_e010          (h_e010),
        .i_e011          (h_e011),
        .i_e100          (h_e100),
        .i_e101          (h_e101),
        .i_e110          (h_e110),
        .i_e111          (h_e111),
        .i_pi            (h_pi),
        .i_aux_node      (h_aux),
        .i_node_total    (h_total),
        .i_ctl           (h_ctl),
        .i_m_ready       (i_m_tready),
        .o_m_valid       (o_m_tvalid),
        .o_term_kind     (o_m_tuser),
        .o_first_node    (b_first),
        .o_second_node   (b_second),
        .o_w00           (b_w00),
        .o_w01           (b_w01),
        .o_w10           (b_w10),
        .o_w11           (b_w11),
        .o_nonsubmodular (b_ns),
        .o_node_total    (b_total),
        .o_last_term     (o_m_tlast)
    );

    // Pack the result beat, first field lowest, zero-filled to whole bytes.
    assign o_m_tdata = OUT_W'({b_total, b_ns, b_w11, b_w10, b_w01, b_w00,
                               b_second, b_first});

endmodule
